### rtl/sprite_multiplexer_sort_unit_macros.svh
// Assertion macros shared by the sprite multiplexer sort unit RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SPRITE_MULTIPLEXER_SORT_UNIT_MACROS_SVH
`define SPRITE_MULTIPLEXER_SORT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/smx_pkg.sv
// Package of the sprite multiplexer sort unit: constants, codes and shared types.
// Used by smx_store, smx_seq and sprite_multiplexer_sort_unit; no dependencies.
`default_nettype none

package smx_pkg;

   localparam int NUM_SPRITES_DEF = 16;
   localparam int SPR_W           = 6;
   localparam int REQ_DATA_W      = 56;
   localparam int RSP_DATA_W      = 48;
   localparam logic [7:0] Y_HIDDEN = 8'hFF;

   typedef enum logic [1:0] {
      FUNC_SET  = 2'd0,
      FUNC_MOVE = 2'd1,
      FUNC_HIDE = 2'd2,
      FUNC_SORT = 2'd3
   } smx_func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_RD,
      ST_KEY_Y,
      ST_KEY_CAP,
      ST_PREV_RD,
      ST_PREV_Y,
      ST_CMP,
      ST_PLACE,
      ST_EM_ORD,
      ST_EM_ATTR,
      ST_EM_OUT
   } smx_state_type;

   typedef struct packed {
      smx_func_type        func;
      logic [SPR_W-1:0]    sprite_index;
      logic signed [15:0]  x_position;
      logic signed [15:0]  y_position;
      logic [7:0]          image;
      logic [7:0]          color;
   } smx_req_type;

   typedef struct packed {
      logic [7:0] y;
      logic [8:0] x;
      logic [7:0] image;
      logic [7:0] color;
   } smx_attr_type;

   typedef struct packed {
      logic             y_we;
      logic             x_we;
      logic             ic_we;
      logic [SPR_W-1:0] addr;
      smx_attr_type     data;
   } smx_attr_wr_type;

   typedef struct packed {
      logic [SPR_W-1:0] slot;
      logic [SPR_W-1:0] sprite;
      smx_attr_type     attr;
      logic             last;
   } smx_rsp_type;

endpackage

`default_nettype wire

### rtl/smx_store.sv
// Sprite attribute memories and the persistent sort order memory, with reset valid bits.
// Depends on smx_pkg.
`default_nettype none

module smx_store #(
   parameter int NUM_SPRITES = smx_pkg::NUM_SPRITES_DEF,
   parameter int IDX_W       = $clog2(NUM_SPRITES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire smx_pkg::smx_attr_wr_type attr_wr,
   input  wire logic                   attr_re,
   input  wire logic [IDX_W-1:0]       attr_raddr,
   output smx_pkg::smx_attr_type       attr_rd,
   input  wire logic                   ord_we,
   input  wire logic [IDX_W-1:0]       ord_waddr,
   input  wire logic [IDX_W-1:0]       ord_wdata,
   input  wire logic                   ord_re,
   input  wire logic [IDX_W-1:0]       ord_raddr,
   output logic [IDX_W-1:0]            ord_rdata
);
   import smx_pkg::*;

   logic [7:0]       y_mem   [NUM_SPRITES];
   logic [8:0]       x_mem   [NUM_SPRITES];
   logic [15:0]      ic_mem  [NUM_SPRITES];
   logic [IDX_W-1:0] ord_mem [NUM_SPRITES];

   logic [NUM_SPRITES-1:0] y_vld_ff, x_vld_ff, ic_vld_ff, ord_vld_ff;
   logic [NUM_SPRITES-1:0] y_vld_in, x_vld_in, ic_vld_in, ord_vld_in;

   logic [7:0]       y_rd_ff;
   logic [8:0]       x_rd_ff;
   logic [15:0]      ic_rd_ff;
   logic             y_rv_ff, x_rv_ff, ic_rv_ff;
   logic [IDX_W-1:0] ord_rd_ff, ord_ra_ff;
   logic             ord_rv_ff;

   logic [IDX_W-1:0] wa;

   assign wa = attr_wr.addr[IDX_W-1:0];

   always_comb begin
      y_vld_in   = y_vld_ff;
      x_vld_in   = x_vld_ff;
      ic_vld_in  = ic_vld_ff;
      ord_vld_in = ord_vld_ff;
      if (attr_wr.y_we) begin
         y_vld_in[wa] = 1'b1;
      end
      if (attr_wr.x_we) begin
         x_vld_in[wa] = 1'b1;
      end
      if (attr_wr.ic_we) begin
         ic_vld_in[wa] = 1'b1;
      end
      if (ord_we) begin
         ord_vld_in[ord_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_vld_ff   <= '0;
         x_vld_ff   <= '0;
         ic_vld_ff  <= '0;
         ord_vld_ff <= '0;
      end else begin
         y_vld_ff   <= y_vld_in;
         x_vld_ff   <= x_vld_in;
         ic_vld_ff  <= ic_vld_in;
         ord_vld_ff <= ord_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (attr_wr.y_we) begin
         y_mem[wa] <= attr_wr.data.y;
      end
      if (attr_wr.x_we) begin
         x_mem[wa] <= attr_wr.data.x;
      end
      if (attr_wr.ic_we) begin
         ic_mem[wa] <= {attr_wr.data.image, attr_wr.data.color};
      end
      if (attr_re) begin
         y_rd_ff  <= y_mem[attr_raddr];
         x_rd_ff  <= x_mem[attr_raddr];
         ic_rd_ff <= ic_mem[attr_raddr];
         y_rv_ff  <= y_vld_ff[attr_raddr];
         x_rv_ff  <= x_vld_ff[attr_raddr];
         ic_rv_ff <= ic_vld_ff[attr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      if (ord_re) begin
         ord_rd_ff <= ord_mem[ord_raddr];
         ord_rv_ff <= ord_vld_ff[ord_raddr];
         ord_ra_ff <= ord_raddr;
      end
   end

   // Entries never written read as their reset values.
   always_comb begin
      attr_rd.y     = y_rv_ff  ? y_rd_ff        : Y_HIDDEN;
      attr_rd.x     = x_rv_ff  ? x_rd_ff        : 9'd0;
      attr_rd.image = ic_rv_ff ? ic_rd_ff[15:8] : 8'd0;
      attr_rd.color = ic_rv_ff ? ic_rd_ff[7:0]  : 8'd0;
      ord_rdata     = ord_rv_ff ? ord_rd_ff     : ord_ra_ff;
   end

endmodule

`default_nettype wire

### rtl/smx_seq.sv
// Sequencer of the sprite multiplexer sort unit: table updates, insertion sort with one
// shared y comparator, and the sorted read-out. Depends on smx_pkg and the macros header.
`default_nettype none
`include "sprite_multiplexer_sort_unit_macros.svh"

module smx_seq #(
   parameter int NUM_SPRITES = smx_pkg::NUM_SPRITES_DEF,
   parameter int IDX_W       = $clog2(NUM_SPRITES)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire smx_pkg::smx_req_type    req,
   output smx_pkg::smx_attr_wr_type     attr_wr,
   output logic                         attr_re,
   output logic [IDX_W-1:0]             attr_raddr,
   input  wire smx_pkg::smx_attr_type   attr_rd,
   output logic                         ord_we,
   output logic [IDX_W-1:0]             ord_waddr,
   output logic [IDX_W-1:0]             ord_wdata,
   output logic                         ord_re,
   output logic [IDX_W-1:0]             ord_raddr,
   input  wire logic [IDX_W-1:0]        ord_rdata,
   input  wire logic                    out_free,
   output logic                         emit_valid,
   output smx_pkg::smx_rsp_type         emit
);
   import smx_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SPRITES - 1);
   localparam logic [SPR_W:0]   NUM_LIMIT = (SPR_W + 1)'(NUM_SPRITES);

   smx_state_type    state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [7:0]       ky_ff, ky_in;

   logic       y_less;
   logic       idx_ok;
   logic       pos_bad;
   logic [7:0] y_store;

   // The single comparator shared by every insertion step.
   assign y_less  = ky_ff < attr_rd.y;
   assign idx_ok  = {1'b0, req.sprite_index} < NUM_LIMIT;
   assign pos_bad = (req.y_position[15:8] != 8'd0) || (req.x_position[15:9] != 7'd0);
   assign y_store = pos_bad ? Y_HIDDEN : req.y_position[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      prev_ff <= prev_in;
      ky_ff   <= ky_in;
   end

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      key_in     = key_ff;
      prev_in    = prev_ff;
      ky_in      = ky_ff;
      req_ready  = 1'b0;
      attr_wr    = '0;
      attr_re    = 1'b0;
      attr_raddr = ord_rdata;
      ord_we     = 1'b0;
      ord_waddr  = j_ff;
      ord_wdata  = key_ff;
      ord_re     = 1'b0;
      ord_raddr  = i_ff;
      emit_valid = 1'b0;
      emit.slot   = SPR_W'(k_ff);
      emit.sprite = SPR_W'(prev_ff);
      emit.attr   = attr_rd;
      emit.last   = (k_ff == LAST_IDX);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req.func == FUNC_SORT) begin
                  i_in     = IDX_W'(1);
                  state_in = ST_KEY_RD;
               end else if (idx_ok) begin
                  attr_wr.addr       = req.sprite_index;
                  attr_wr.y_we       = 1'b1;
                  attr_wr.x_we       = (req.func != FUNC_HIDE);
                  attr_wr.ic_we      = (req.func == FUNC_SET);
                  attr_wr.data.y     = (req.func == FUNC_HIDE) ? Y_HIDDEN : y_store;
                  attr_wr.data.x     = req.x_position[8:0];
                  attr_wr.data.image = req.image;
                  attr_wr.data.color = req.color;
               end
            end
         end
         ST_KEY_RD: begin
            ord_re    = 1'b1;
            ord_raddr = i_ff;
            state_in  = ST_KEY_Y;
         end
         ST_KEY_Y: begin
            key_in   = ord_rdata;
            attr_re  = 1'b1;
            j_in     = i_ff;
            state_in = ST_KEY_CAP;
         end
         ST_KEY_CAP: begin
            ky_in    = attr_rd.y;
            state_in = ST_PREV_RD;
         end
         ST_PREV_RD: begin
            if (j_ff == '0) begin
               state_in = ST_PLACE;
            end else begin
               ord_re    = 1'b1;
               ord_raddr = j_ff - IDX_W'(1);
               state_in  = ST_PREV_Y;
            end
         end
         ST_PREV_Y: begin
            prev_in  = ord_rdata;
            attr_re  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (y_less) begin
               ord_we    = 1'b1;
               ord_wdata = prev_ff;
               j_in      = j_ff - IDX_W'(1);
               state_in  = ST_PREV_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            ord_we = 1'b1;
            if (i_ff == LAST_IDX) begin
               k_in     = '0;
               state_in = ST_EM_ORD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_KEY_RD;
            end
         end
         ST_EM_ORD: begin
            ord_re    = 1'b1;
            ord_raddr = k_ff;
            state_in  = ST_EM_ATTR;
         end
         ST_EM_ATTR: begin
            prev_in  = ord_rdata;
            attr_re  = 1'b1;
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (out_free) begin
               emit_valid = 1'b1;
               if (k_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_EM_ORD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SMX_ASSERT_IMPL(a_shift_above_top, clock, reset, (state_ff == ST_CMP) && y_less, j_ff != '0, "Sort shifted past rank zero.")
   `SMX_ASSERT_NEXT(a_sort_start, clock, reset, req_valid && req_ready && (req.func == FUNC_SORT), state_ff == ST_KEY_RD, "Sort item did not start the sort.")
   `SMX_ASSERT_IMPL(a_emit_place, clock, reset, emit_valid, (state_ff == ST_EM_OUT) && out_free, "Result emitted outside read-out or into a full register.")
   `SMX_ASSERT_NEXT(a_last_to_idle, clock, reset, emit_valid && emit.last, state_ff == ST_IDLE, "Read-out did not end after the last sprite.")

endmodule

`default_nettype wire

### rtl/sprite_multiplexer_sort_unit.sv
// Block usage
// Input channel req_: one item per command. tuser carries the function (set, move, hide,
// sort); tdata carries sprite index, signed x and y, image and color bytes.
// Result channel rsp_: a sort item produces one item per sprite in ascending stored y,
// ties kept in their previous order; tlast marks the final sprite. Other commands
// produce no item.
// Set, move and hide are done while idle: ready stays high and the next item is taken in
// the following cycle. A sort reads each key and its y, compares it with the entries above
// it through the one shared y comparator, shifting each greater entry down, and places it;
// then, per item, the read-out reads the order memory, then the attribute memories, and
// emits. Each step waits on the registered reads of the order and attribute memories.
// req_tready is low from the taking of the sort item until the read-out ends.
// Synchronous reset hides all sprites, clears x, image and color and restores the
// identity order; no memory clearing pass is needed.
// A stalled receiver holds the read-out: one output register keeps the pending item and
// the sequencer waits until it is taken.
// Depends on smx_pkg, smx_store and smx_seq.
`default_nettype none

module sprite_multiplexer_sort_unit #(
   parameter int NUM_SPRITES = smx_pkg::NUM_SPRITES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // func[1:0]
   input  wire logic [1:0]                       req_tuser,
   // sprite_index[5:0], x_position[21:6], y_position[37:22], image[45:38], color[53:46]
   input  wire logic [smx_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // slot[5:0], sprite_number[11:6], y_out[19:12], x_out[28:20], image_out[36:29],
   // color_out[44:37]
   output logic [smx_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);
   import smx_pkg::*;

   localparam int IDX_W = $clog2(NUM_SPRITES);

   smx_req_type      req;
   smx_attr_wr_type  attr_wr;
   smx_attr_type     attr_rd;
   logic             attr_re;
   logic [IDX_W-1:0] attr_raddr;
   logic             ord_we, ord_re;
   logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
   logic             out_free;
   logic             emit_valid;
   smx_rsp_type      emit;

   logic             rsp_valid_ff;
   smx_rsp_type      rsp_ff;

   assign req.func         = smx_func_type'(req_tuser);
   assign req.sprite_index = req_tdata[5:0];
   assign req.x_position   = req_tdata[21:6];
   assign req.y_position   = req_tdata[37:22];
   assign req.image        = req_tdata[45:38];
   assign req.color        = req_tdata[53:46];

   assign out_free = !rsp_valid_ff || rsp_tready;

   smx_store #(
      .NUM_SPRITES (NUM_SPRITES),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .attr_wr    (attr_wr),
      .attr_re    (attr_re),
      .attr_raddr (attr_raddr),
      .attr_rd    (attr_rd),
      .ord_we     (ord_we),
      .ord_waddr  (ord_waddr),
      .ord_wdata  (ord_wdata),
      .ord_re     (ord_re),
      .ord_raddr  (ord_raddr),
      .ord_rdata  (ord_rdata)
   );

   smx_seq #(
      .NUM_SPRITES (NUM_SPRITES),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .attr_wr    (attr_wr),
      .attr_re    (attr_re),
      .attr_raddr (attr_raddr),
      .attr_rd    (attr_rd),
      .ord_we     (ord_we),
      .ord_waddr  (ord_waddr),
      .ord_wdata  (ord_wdata),
      .ord_re     (ord_re),
      .ord_raddr  (ord_raddr),
      .ord_rdata  (ord_rdata),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit       (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_ff <= emit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {3'b000, rsp_ff.attr.color, rsp_ff.attr.image, rsp_ff.attr.x,
                        rsp_ff.attr.y, rsp_ff.sprite, rsp_ff.slot};

endmodule

`default_nettype wire
